@@ src/vlct_pkg.sv @@
// Package for the value list table: sizes, operation and status codes,
// controller states and value, index and count helpers. No dependencies.
`default_nettype none

package vlct_pkg;

  localparam int CAPACITY   = 16;
  localparam int VALUE_BITS = 32;

  localparam int KEY_BITS       = 32;
  localparam int OUT_INDEX_BITS = 4;
  localparam int OUT_COUNT_BITS = 5;

  localparam int IDX_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_SEARCH = 2'd1,
    OP_UPDATE = 2'd2,
    OP_DELETE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_MISSING = 2'd1,
    STAT_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_t;

  function automatic value_t fit_value(input logic [KEY_BITS-1:0] v);
    logic [63:0] w;
    w = {32'b0, v};
    return w[VALUE_BITS-1:0];
  endfunction

  function automatic logic [OUT_INDEX_BITS-1:0] to_out_index(input idx_t p);
    logic [15:0] w;
    w = 16'(p);
    return w[OUT_INDEX_BITS-1:0];
  endfunction

  function automatic logic [OUT_COUNT_BITS-1:0] to_out_count(input count_t c);
    logic [15:0] w;
    w = 16'(c);
    return w[OUT_COUNT_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

@@ src/vlct_if.sv @@
// Request and response channel interfaces for the value list table.
// Depend on vlct_pkg for the operation and status codes and the field widths.
`default_nettype none

interface vlct_req_if;
  logic                          valid;
  logic                          ready;
  vlct_pkg::op_t                 operation;
  logic [vlct_pkg::KEY_BITS-1:0] key_value;
  logic [vlct_pkg::KEY_BITS-1:0] new_value;

  modport source (output valid, operation, key_value, new_value, input ready);
  modport sink   (input valid, operation, key_value, new_value, output ready);
endinterface

interface vlct_rsp_if;
  logic                                valid;
  logic                                ready;
  vlct_pkg::status_t                   status;
  logic [vlct_pkg::OUT_INDEX_BITS-1:0] match_index;
  logic [vlct_pkg::OUT_COUNT_BITS-1:0] entry_count;

  modport source (output valid, status, match_index, entry_count, input ready);
  modport sink   (input valid, status, match_index, entry_count, output ready);
endinterface

`default_nettype wire

@@ src/value_list_crud_table.sv @@
// Value list table: unsorted list in one synchronous RAM with a linear scan.
// Depends on vlct_pkg and the vlct_req_if / vlct_rsp_if interfaces.
//
// Usage:
//   req carries one word per operation: operation, key_value, new_value.
//   rsp returns one word per request: status, match_index, entry_count.
//   Append writes its entry as the request is accepted. Search and update scan
//   the list one entry per cycle through the RAM read port, up to the first
//   match or to the end of the list on a miss. Delete scans to the match,
//   then moves each later entry down one place, one entry per cycle (read and
//   write port each cycle).
//   One request is worked on at a time; req.ready is high only while idle,
//   so the next request can be accepted in the cycle after a result is loaded.
//   A finished result sits in the output register; the next request is
//   accepted while it waits, and that request's result waits in turn until
//   rsp.ready frees the register.
//   Reset clears the count and all control state; the RAM keeps no reset
//   and only entries below the count are ever read.
`default_nettype none

module value_list_crud_table (
  input  wire logic  clk,
  input  wire logic  rst,
  vlct_req_if.sink   req,
  vlct_rsp_if.source rsp
);
  import vlct_pkg::*;

  value_t mem [CAPACITY];
  value_t rdata;

  state_t  state, state_next;
  op_t     op, op_next;
  value_t  key, key_next;
  value_t  repl, repl_next;
  idx_t    ptr, ptr_next;
  count_t  fill, fill_next;
  status_t res_status, res_status_next;
  idx_t    res_index, res_index_next;

  logic                      out_valid, out_valid_next;
  status_t                   out_status, out_status_next;
  logic [OUT_INDEX_BITS-1:0] out_index, out_index_next;
  logic [OUT_COUNT_BITS-1:0] out_count, out_count_next;

  logic   wr_en, rd_en;
  idx_t   wr_addr, rd_addr;
  value_t wr_data;

  count_t ptr_ext;
  logic   more_scan, more_shift;

  assign ptr_ext    = count_t'(ptr);
  assign more_scan  = (ptr_ext + count_t'(1)) < fill;
  assign more_shift = (ptr_ext + count_t'(1)) < (fill - count_t'(1));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      out_valid <= out_valid_next;
    end
    op         <= op_next;
    key        <= key_next;
    repl       <= repl_next;
    ptr        <= ptr_next;
    res_status <= res_status_next;
    res_index  <= res_index_next;
    out_status <= out_status_next;
    out_index  <= out_index_next;
    out_count  <= out_count_next;
  end

  always_comb begin
    state_next      = state;
    op_next         = op;
    key_next        = key;
    repl_next       = repl;
    ptr_next        = ptr;
    fill_next       = fill;
    res_status_next = res_status;
    res_index_next  = res_index;
    out_valid_next  = out_valid && !rsp.ready;
    out_status_next = out_status;
    out_index_next  = out_index;
    out_count_next  = out_count;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_data         = '0;
    rd_en           = 1'b0;
    rd_addr         = '0;
    req.ready       = (state == S_IDLE);

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          op_next         = req.operation;
          key_next        = fit_value(req.key_value);
          repl_next       = fit_value(req.new_value);
          ptr_next        = '0;
          res_index_next  = '0;
          res_status_next = STAT_DONE;
          if (req.operation == OP_APPEND) begin
            if (fill == count_t'(CAPACITY)) begin
              res_status_next = STAT_FULL;
            end else begin
              wr_en          = 1'b1;
              wr_addr        = fill[IDX_BITS-1:0];
              wr_data        = fit_value(req.key_value);
              res_index_next = fill[IDX_BITS-1:0];
              fill_next      = fill + count_t'(1);
            end
            state_next = S_FINISH;
          end else if (fill == '0) begin
            res_status_next = STAT_MISSING;
            state_next      = S_FINISH;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = '0;
            state_next = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (rdata == key) begin
          res_status_next = STAT_DONE;
          res_index_next  = ptr;
          state_next      = S_FINISH;
          unique case (op)
            OP_UPDATE: begin
              wr_en   = 1'b1;
              wr_addr = ptr;
              wr_data = repl;
            end
            OP_DELETE: begin
              if (more_scan) begin
                rd_en      = 1'b1;
                rd_addr    = idx_t'(ptr_ext + count_t'(1));
                state_next = S_SHIFT;
              end else begin
                fill_next = fill - count_t'(1);
              end
            end
            OP_SEARCH, OP_APPEND: begin
            end
          endcase
        end else if (more_scan) begin
          rd_en    = 1'b1;
          rd_addr  = idx_t'(ptr_ext + count_t'(1));
          ptr_next = idx_t'(ptr_ext + count_t'(1));
        end else begin
          res_status_next = STAT_MISSING;
          res_index_next  = '0;
          state_next      = S_FINISH;
        end
      end

      S_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = ptr;
        wr_data = rdata;
        if (more_shift) begin
          rd_en    = 1'b1;
          rd_addr  = idx_t'(ptr_ext + count_t'(2));
          ptr_next = idx_t'(ptr_ext + count_t'(1));
        end else begin
          fill_next  = fill - count_t'(1);
          state_next = S_FINISH;
        end
      end

      S_FINISH: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next  = 1'b1;
          out_status_next = res_status;
          out_index_next  = to_out_index(res_index);
          out_count_next  = to_out_count(fill);
          state_next      = S_IDLE;
        end
      end
    endcase
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.match_index = out_index;
  assign rsp.entry_count = out_count;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= count_t'(CAPACITY))
    else $error("entry count above capacity");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while previous one in flight");

  a_shift_ports: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT && rd_en |-> rd_addr != wr_addr)
    else $error("shift reads the entry it writes");

  a_finish_load: assert property (@(posedge clk) disable iff (rst)
    state == S_FINISH && !out_valid |=> out_valid && state == S_IDLE)
    else $error("free output register not loaded");

endmodule

`default_nettype wire
